// ===== src/sfr_pkg.sv =====
// Shared types, constants and the CRC byte update for the status frame receiver.
// No dependencies; every other file of the block imports this package.
package sfr_pkg;

  localparam int MAX_FRAME_BYTES_DEF  = 47;
  localparam int CRC_START_OFFSET_DEF = 12;

  localparam int HDR_LEN     = 10;
  localparam int FRAME_LEN_W = 6;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] ASCII_CR = 8'h0D;
  localparam logic [7:0] ASCII_LF = 8'h0A;

  // Ten-byte headers of a supply frame and a data frame, first byte at index 0.
  localparam logic [7:0] SUP_HDR [HDR_LEN] = '{
    8'h43, 8'h4D, 8'h32, 8'h30, 8'h32, 8'h34, 8'h20, 8'h53, 8'h55, 8'h50
  };
  localparam logic [7:0] DAT_HDR [HDR_LEN] = '{
    8'h43, 8'h4D, 8'h32, 8'h30, 8'h32, 8'h34, 8'h20, 8'h44, 8'h41, 8'h54
  };

  typedef enum logic [1:0] {
    KIND_SUPPLY  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_UNKNOWN = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } byte_item_t;

  typedef struct packed {
    frame_kind_t            frame_kind;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   crc_ok;
    logic [15:0]            crc_computed;
    logic [15:0]            crc_received;
    logic                   during_resync;
  } frame_item_t;

  // CRC-16/Modbus update by one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/sfr_frame_core.sv =====
// Frame state of the status frame receiver: byte count, header match, delayed CRC.
// Builds the result of a byte that closes a frame. Depends on sfr_pkg.
module sfr_frame_core #(
  parameter int MAX_FRAME_BYTES  = sfr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int CRC_START_OFFSET = sfr_pkg::CRC_START_OFFSET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sfr_pkg::byte_item_t item,
  output logic                result_valid,
  output sfr_pkg::frame_item_t result
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_LEN  = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] FOLD_POS = CNT_W'(CRC_START_OFFSET + 4);
  localparam logic [CNT_W-1:0] HDR_POS  = CNT_W'(HDR_LEN);

  logic [CNT_W-1:0] byte_count;
  logic [7:0]       recent_bytes [4];
  logic [15:0]      running_crc;
  logic             supply_header_match;
  logic             data_header_match;
  logic             resync_mode;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] len;
  logic [7:0]       rec_eff [4];
  logic [15:0]      crc_eff;
  logic             sup_eff;
  logic             dat_eff;
  logic             resync_eff;
  logic [15:0]      crc_next;
  logic             sup_next;
  logic             dat_next;
  logic             done;
  logic [15:0]      crc_rx;

  always_comb begin
    // A restart clears the frame state before the byte is taken.
    if (item.restart) begin
      pos     = '0;
      crc_eff = CRC_INIT;
      sup_eff = 1'b1;
      dat_eff = 1'b1;
      for (int i = 0; i < 4; i++) rec_eff[i] = 8'h00;
    end else begin
      pos     = byte_count;
      crc_eff = running_crc;
      sup_eff = supply_header_match;
      dat_eff = data_header_match;
      for (int i = 0; i < 4; i++) rec_eff[i] = recent_bytes[i];
    end
    resync_eff = item.restart | resync_mode;

    sup_next = sup_eff;
    dat_next = dat_eff;
    if (pos < HDR_POS) begin
      if (item.rx_byte != SUP_HDR[pos[3:0]]) sup_next = 1'b0;
      if (item.rx_byte != DAT_HDR[pos[3:0]]) dat_next = 1'b0;
    end

    // The CRC trails the input by four bytes, so the CRC field and trailer stay out.
    crc_next = (pos >= FOLD_POS) ? crc_byte(crc_eff, rec_eff[3]) : crc_eff;
    crc_rx   = {rec_eff[2], rec_eff[1]};

    len  = pos + 1'b1;
    done = (len >= MAX_LEN) ||
           (resync_eff && rec_eff[0] == ASCII_CR && item.rx_byte == ASCII_LF);

    result_valid         = accept && done;
    result.frame_length  = FRAME_LEN_W'(len);
    result.during_resync = resync_eff;
    result.frame_kind    = KIND_UNKNOWN;
    result.crc_ok        = 1'b0;
    result.crc_computed  = 16'h0000;
    result.crc_received  = 16'h0000;
    if (len >= HDR_POS && sup_next) begin
      result.frame_kind = KIND_SUPPLY;
    end else if (len >= HDR_POS && dat_next) begin
      result.frame_kind   = KIND_DATA;
      result.crc_computed = crc_next;
      result.crc_received = crc_rx;
      result.crc_ok       = (crc_next == crc_rx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count          <= '0;
      running_crc         <= CRC_INIT;
      supply_header_match <= 1'b1;
      data_header_match   <= 1'b1;
      resync_mode         <= 1'b1;
      for (int i = 0; i < 4; i++) recent_bytes[i] <= 8'h00;
    end else if (accept) begin
      if (done) begin
        byte_count          <= '0;
        running_crc         <= CRC_INIT;
        supply_header_match <= 1'b1;
        data_header_match   <= 1'b1;
        resync_mode         <= 1'b0;
        for (int i = 0; i < 4; i++) recent_bytes[i] <= 8'h00;
      end else begin
        byte_count          <= len;
        running_crc         <= crc_next;
        supply_header_match <= sup_next;
        data_header_match   <= dat_next;
        resync_mode         <= resync_eff;
        recent_bytes[0]     <= item.rx_byte;
        recent_bytes[1]     <= rec_eff[0];
        recent_bytes[2]     <= rec_eff[1];
        recent_bytes[3]     <= rec_eff[2];
      end
    end
  end

endmodule

// ===== src/status_frame_receiver_crc_check.sv =====
// Top level of the status frame receiver with CRC-16/Modbus check.
// Depends on sfr_pkg and sfr_frame_core.
//
// Usage:
//   The byte channel (byte_valid, byte_ready, byte_item) takes one received
//   serial byte per item, with a restart flag that drops any partial frame and
//   enters resync mode before that byte. The frame channel (frame_valid,
//   frame_ready, frame_item) gives one item per completed frame: kind, length,
//   CRC check and whether it ended in resync mode.
//   The result of the byte that closes a frame is registered into frame_item,
//   or into the skid entry if frame_item holds an item not taken. Throughput:
//   one byte per cycle while byte_ready is high; the header compare, CRC byte
//   update and end-of-frame test sit between frame state and result registers.
//   A result register plus one skid entry hold finished items. While the
//   receiver stalls, bytes keep flowing until both entries are full; then
//   byte_ready falls until frame_ready returns.
//   Reset clears the frame state, enters resync mode and empties both entries.
module status_frame_receiver_crc_check #(
  parameter int MAX_FRAME_BYTES  = sfr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int CRC_START_OFFSET = sfr_pkg::CRC_START_OFFSET_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  sfr_pkg::byte_item_t  byte_item,
  output logic                 frame_valid,
  input  logic                 frame_ready,
  output sfr_pkg::frame_item_t frame_item
);
  import sfr_pkg::*;

  logic        accept;
  logic        res_valid;
  frame_item_t res_item;
  logic        pop;
  logic        skid_valid;
  frame_item_t skid_item;

  assign byte_ready = !skid_valid;
  assign accept     = byte_valid && byte_ready;
  assign pop        = frame_valid && frame_ready;

  sfr_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .CRC_START_OFFSET(CRC_START_OFFSET)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (byte_item),
    .result_valid(res_valid),
    .result      (res_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (res_valid) begin
      if (frame_valid && !pop) skid_valid <= 1'b1;
      else frame_valid <= 1'b1;
    end else if (pop) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) frame_item <= skid_item;
    end else if (res_valid) begin
      if (frame_valid && !pop) skid_item <= res_item;
      else frame_item <= res_item;
    end
  end

  // The skid entry only ever holds an item younger than the one on the port.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> frame_valid)
    else $error("skid entry holds an item while the result register is empty");

  // Only a frame ended in resync mode can be shorter than the full length.
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_item.during_resync) |->
      (frame_item.frame_length == FRAME_LEN_W'(MAX_FRAME_BYTES)))
    else $error("short frame reported outside resync mode");

  a_non_data_zero: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_item.frame_kind != KIND_DATA) |->
      (!frame_item.crc_ok && frame_item.crc_computed == 16'h0000 &&
       frame_item.crc_received == 16'h0000))
    else $error("CRC fields set on a frame that is not a data frame");

  a_crc_ok: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_item.frame_kind == KIND_DATA) |->
      (frame_item.crc_ok == (frame_item.crc_computed == frame_item.crc_received)))
    else $error("crc_ok disagrees with the CRC fields");

endmodule
